@@ hw/rtl/campose_pkg.sv @@
// ----------------------------------------------------------------------------
// campose_pkg: shared types and constants for the camera pose update block
// Command codes, register indexes, microcode encodings for the shared
// multiply unit, and the microcode table for the move, lift and turn commands.
// ----------------------------------------------------------------------------
`default_nettype none

package campose_pkg;

  // Widths fixed by the channel and register formats
  localparam int COORD_BITS_DEFAULT = 32;
  localparam int FIELD_W            = 32;
  localparam int CMD_W              = 3;
  localparam int UP_W               = 16;
  localparam int GAIN_W             = 16;
  localparam int CFG_INDEX_W        = 3;
  localparam int CFG_DATA_W         = 16;
  localparam int B_W                = 32;  // multiplier coefficient operand
  localparam int STEP_W             = 5;   // longest program has 19 steps

  // Q1.30 rotation coefficients for 0.1 degree
  localparam logic signed [B_W-1:0] ROT_COS = 32'sd1073740189;
  localparam logic signed [B_W-1:0] ROT_SIN = 32'sd1874032;
  localparam logic signed [B_W-1:0] ROT_OMC = 32'sd1635;

  // Register reset values
  localparam logic signed [UP_W-1:0] UP_X_RESET      = 16'sd0;
  localparam logic signed [UP_W-1:0] UP_Y_RESET      = 16'sd16384;
  localparam logic signed [UP_W-1:0] UP_Z_RESET      = 16'sd0;
  localparam logic [GAIN_W-1:0]      MOVE_GAIN_RESET = 16'd655;
  localparam logic [GAIN_W-1:0]      LIFT_GAIN_RESET = 16'd66;

  // 32-bit output saturation limits
  localparam logic signed [63:0] SAT32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] SAT32_MIN = -64'sd2147483648;

  typedef enum logic [CMD_W-1:0] {
    CMD_NONE     = 3'd0,
    CMD_FWD      = 3'd1,
    CMD_BACK     = 3'd2,
    CMD_TURN_POS = 3'd3,
    CMD_TURN_NEG = 3'd4,
    CMD_DOWN     = 3'd5,
    CMD_UP       = 3'd6,
    CMD_LOAD     = 3'd7
  } cmd_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_UP_X      = 3'd0,
    REG_UP_Y      = 3'd1,
    REG_UP_Z      = 3'd2,
    REG_MOVE_GAIN = 3'd3,
    REG_LIFT_GAIN = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_P0,
    S_P1,
    S_P2,
    S_OUT
  } seq_state_t;

  typedef enum logic [1:0] {
    MUL_HOLD,
    MUL_LO,
    MUL_HI
  } mul_op_t;

  typedef enum logic [1:0] {
    KIND_MOVE,
    KIND_LIFT,
    KIND_TURN
  } kind_t;

  typedef enum logic [1:0] {
    SH14,
    SH16,
    SH30
  } shift_t;

  typedef enum logic [3:0] {
    A_HD0, A_HD1, A_HD2,
    A_UP0, A_UP1, A_UP2,
    A_C0, A_C1, A_C2,
    A_D, A_T
  } a_sel_t;

  typedef enum logic [2:0] {
    B_UP0, B_UP1, B_UP2,
    B_MOVE, B_LIFT,
    B_COS, B_SIN, B_OMC
  } b_sel_t;

  typedef enum logic [1:0] {
    BASE_ZERO,
    BASE_DST,
    BASE_R
  } base_t;

  typedef enum logic [3:0] {
    D_POS0, D_POS1, D_POS2,
    D_HD0, D_HD1, D_HD2,
    D_C0, D_C1, D_C2,
    D_D, D_T, D_R
  } dst_t;

  // One microcode step: dst = base +/- round(a * b >> shift)
  typedef struct packed {
    a_sel_t a_sel;
    b_sel_t b_sel;
    shift_t sh;
    base_t  base;
    dst_t   dst;
    logic   neg;      // subtract the product
    logic   dirflip;  // flip the sign for back, down and negative turn
    logic   last;
  } uop_t;

  // Sequencer to datapath control
  typedef struct packed {
    mul_op_t mul;
    shift_t  sh;
    a_sel_t  a_sel;
    b_sel_t  b_sel;
    base_t   base;
    dst_t    dst;
    logic    neg;
    logic    wr;
    logic    load;
    logic    out_load;
  } ctl_t;

  function automatic logic signed [FIELD_W-1:0] sat32(input logic signed [63:0] v);
    if (v > SAT32_MAX) begin
      return FIELD_W'(SAT32_MAX);
    end else if (v < SAT32_MIN) begin
      return FIELD_W'(SAT32_MIN);
    end
    return FIELD_W'(v);
  endfunction

  function automatic uop_t mk_uop(input a_sel_t a, input b_sel_t b, input shift_t sh,
                                  input base_t base, input dst_t dst, input logic neg,
                                  input logic dirflip, input logic last);
    uop_t u;
    u.a_sel   = a;
    u.b_sel   = b;
    u.sh      = sh;
    u.base    = base;
    u.dst     = dst;
    u.neg     = neg;
    u.dirflip = dirflip;
    u.last    = last;
    return u;
  endfunction

  // Microcode table per command kind
  function automatic uop_t uop_lookup(input kind_t kind, input logic [STEP_W-1:0] step);
    uop_t u;
    u = mk_uop(A_HD0, B_UP0, SH14, BASE_ZERO, D_R, 1'b0, 1'b0, 1'b1);
    case (kind)
      KIND_MOVE: begin
        case (step)
          5'd0:    u = mk_uop(A_HD0, B_MOVE, SH16, BASE_DST, D_POS0, 1'b0, 1'b1, 1'b0);
          5'd1:    u = mk_uop(A_HD1, B_MOVE, SH16, BASE_DST, D_POS1, 1'b0, 1'b1, 1'b0);
          default: u = mk_uop(A_HD2, B_MOVE, SH16, BASE_DST, D_POS2, 1'b0, 1'b1, 1'b1);
        endcase
      end
      KIND_LIFT: begin
        case (step)
          5'd0:    u = mk_uop(A_UP0, B_LIFT, SH14, BASE_DST, D_POS0, 1'b0, 1'b1, 1'b0);
          5'd1:    u = mk_uop(A_UP1, B_LIFT, SH14, BASE_DST, D_POS1, 1'b0, 1'b1, 1'b0);
          default: u = mk_uop(A_UP2, B_LIFT, SH14, BASE_DST, D_POS2, 1'b0, 1'b1, 1'b1);
        endcase
      end
      KIND_TURN: begin
        case (step)
          // cross product k x v
          5'd0:  u = mk_uop(A_HD2, B_UP1, SH14, BASE_ZERO, D_C0, 1'b0, 1'b0, 1'b0);
          5'd1:  u = mk_uop(A_HD1, B_UP2, SH14, BASE_DST,  D_C0, 1'b1, 1'b0, 1'b0);
          5'd2:  u = mk_uop(A_HD0, B_UP2, SH14, BASE_ZERO, D_C1, 1'b0, 1'b0, 1'b0);
          5'd3:  u = mk_uop(A_HD2, B_UP0, SH14, BASE_DST,  D_C1, 1'b1, 1'b0, 1'b0);
          5'd4:  u = mk_uop(A_HD1, B_UP0, SH14, BASE_ZERO, D_C2, 1'b0, 1'b0, 1'b0);
          5'd5:  u = mk_uop(A_HD0, B_UP1, SH14, BASE_DST,  D_C2, 1'b1, 1'b0, 1'b0);
          // dot product k . v, then scale by 1 - cos
          5'd6:  u = mk_uop(A_HD0, B_UP0, SH14, BASE_ZERO, D_D,  1'b0, 1'b0, 1'b0);
          5'd7:  u = mk_uop(A_HD1, B_UP1, SH14, BASE_DST,  D_D,  1'b0, 1'b0, 1'b0);
          5'd8:  u = mk_uop(A_HD2, B_UP2, SH14, BASE_DST,  D_D,  1'b0, 1'b0, 1'b0);
          5'd9:  u = mk_uop(A_D,   B_OMC, SH30, BASE_ZERO, D_T,  1'b0, 1'b0, 1'b0);
          // per component: v cos +/- c sin + k t
          5'd10: u = mk_uop(A_HD0, B_COS, SH30, BASE_ZERO, D_R,   1'b0, 1'b0, 1'b0);
          5'd11: u = mk_uop(A_C0,  B_SIN, SH30, BASE_DST,  D_R,   1'b0, 1'b1, 1'b0);
          5'd12: u = mk_uop(A_T,   B_UP0, SH14, BASE_R,    D_HD0, 1'b0, 1'b0, 1'b0);
          5'd13: u = mk_uop(A_HD1, B_COS, SH30, BASE_ZERO, D_R,   1'b0, 1'b0, 1'b0);
          5'd14: u = mk_uop(A_C1,  B_SIN, SH30, BASE_DST,  D_R,   1'b0, 1'b1, 1'b0);
          5'd15: u = mk_uop(A_T,   B_UP1, SH14, BASE_R,    D_HD1, 1'b0, 1'b0, 1'b0);
          5'd16: u = mk_uop(A_HD2, B_COS, SH30, BASE_ZERO, D_R,   1'b0, 1'b0, 1'b0);
          5'd17: u = mk_uop(A_C2,  B_SIN, SH30, BASE_DST,  D_R,   1'b0, 1'b1, 1'b0);
          default: u = mk_uop(A_T, B_UP2, SH14, BASE_R,    D_HD2, 1'b0, 1'b0, 1'b1);
        endcase
      end
      default: u = mk_uop(A_HD0, B_UP0, SH14, BASE_ZERO, D_R, 1'b0, 1'b0, 1'b1);
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/campose_if.sv @@
// ----------------------------------------------------------------------------
// campose channel interfaces
// Command channel (command plus load pose) and pose result channel, each
// with valid/ready; a transfer happens when both are high at a clock edge.
// ----------------------------------------------------------------------------
`default_nettype none

interface campose_cmd_if;
  logic                                          valid;
  logic                                          ready;
  logic [campose_pkg::CMD_W-1:0]                 cmd;
  logic signed [campose_pkg::FIELD_W-1:0]        load_pos_x;
  logic signed [campose_pkg::FIELD_W-1:0]        load_pos_y;
  logic signed [campose_pkg::FIELD_W-1:0]        load_pos_z;
  logic signed [campose_pkg::FIELD_W-1:0]        load_target_x;
  logic signed [campose_pkg::FIELD_W-1:0]        load_target_y;
  logic signed [campose_pkg::FIELD_W-1:0]        load_target_z;

  modport source (
    output valid, cmd, load_pos_x, load_pos_y, load_pos_z,
           load_target_x, load_target_y, load_target_z,
    input  ready
  );
  modport sink (
    input  valid, cmd, load_pos_x, load_pos_y, load_pos_z,
           load_target_x, load_target_y, load_target_z,
    output ready
  );
endinterface

interface campose_pose_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [campose_pkg::FIELD_W-1:0] cam_x;
  logic signed [campose_pkg::FIELD_W-1:0] cam_y;
  logic signed [campose_pkg::FIELD_W-1:0] cam_z;
  logic signed [campose_pkg::FIELD_W-1:0] look_x;
  logic signed [campose_pkg::FIELD_W-1:0] look_y;
  logic signed [campose_pkg::FIELD_W-1:0] look_z;

  modport source (
    output valid, cam_x, cam_y, cam_z, look_x, look_y, look_z,
    input  ready
  );
  modport sink (
    input  valid, cam_x, cam_y, cam_z, look_x, look_y, look_z,
    output ready
  );
endinterface

`default_nettype wire

@@ hw/rtl/camera_pose_update.sv @@
// ----------------------------------------------------------------------------
// camera_pose_update: fixed-point first-person camera pose
// Keeps position and heading (Q16.16) and updates them per command.
// ----------------------------------------------------------------------------
// Usage:
//   cmd_ch carries one command with its load pose; pose_ch returns one
//   result per command: camera position and look-at point (position plus
//   heading), both saturated to 32 bits. Up vector and gains are written
//   through wr_en / wr_index / wr_data while no command is in progress.
//   All products go through one shared rounding multiplier, each formed
//   in the steps low half, high half, then round and write back.
//   The command side is ready again the cycle after the result is loaded;
//   a new command is not taken while one is in progress.
//   Reset clears position and heading, loads the register defaults and
//   empties the output register. If the receiver stalls, the finished
//   pose waits in the sequencer until the output register is free; the
//   held result stays stable on pose_ch.
// ----------------------------------------------------------------------------
`default_nettype none

module camera_pose_update #(
  parameter int COORD_BITS = campose_pkg::COORD_BITS_DEFAULT
) (
  input  logic                                   clk,
  input  logic                                   rst,
  campose_cmd_if.sink                            cmd_ch,
  campose_pose_if.source                         pose_ch,
  input  logic                                   wr_en,
  input  logic [campose_pkg::CFG_INDEX_W-1:0]    wr_index,
  input  logic [campose_pkg::CFG_DATA_W-1:0]     wr_data
);

  localparam int CW = COORD_BITS;
  localparam int AW = CW + 8;
  localparam int SW = (AW + 1 > 34) ? AW + 1 : 34;
  localparam int BW = campose_pkg::B_W;
  localparam int FW = campose_pkg::FIELD_W;

  localparam logic signed [SW-1:0] CMAX = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [SW-1:0] CMIN = ~CMAX;

  // configuration
  logic signed [campose_pkg::UP_W-1:0]   up_x, up_y, up_z;
  logic [campose_pkg::GAIN_W-1:0]        move_gain, lift_gain;

  // pose state and scratch values
  logic signed [CW-1:0]  pos [3];
  logic signed [CW-1:0]  hd  [3];
  logic signed [AW-1:0]  cc  [3];
  logic signed [AW-1:0]  dd, tt, rr;

  // datapath
  campose_pkg::ctl_t     ctl;
  logic                  in_ready;
  logic                  out_free;
  logic signed [AW-1:0]  a_val;
  logic signed [BW-1:0]  b_val;
  logic signed [AW-1:0]  m_val;
  logic signed [AW-1:0]  dst_val;
  logic signed [AW-1:0]  base_val;
  logic signed [SW-1:0]  res;
  logic signed [SW-1:0]  ld_p [3];
  logic signed [SW-1:0]  ld_t [3];

  // result register
  logic                  out_valid;
  logic signed [FW-1:0]  out_cam  [3];
  logic signed [FW-1:0]  out_look [3];

  function automatic logic signed [CW-1:0] sat_cw(input logic signed [SW-1:0] v);
    if (v > CMAX) begin
      return CW'(CMAX);
    end else if (v < CMIN) begin
      return CW'(CMIN);
    end
    return CW'(v);
  endfunction

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      up_x      <= campose_pkg::UP_X_RESET;
      up_y      <= campose_pkg::UP_Y_RESET;
      up_z      <= campose_pkg::UP_Z_RESET;
      move_gain <= campose_pkg::MOVE_GAIN_RESET;
      lift_gain <= campose_pkg::LIFT_GAIN_RESET;
    end else if (wr_en) begin
      case (wr_index)
        campose_pkg::REG_UP_X:      up_x      <= $signed(wr_data);
        campose_pkg::REG_UP_Y:      up_y      <= $signed(wr_data);
        campose_pkg::REG_UP_Z:      up_z      <= $signed(wr_data);
        campose_pkg::REG_MOVE_GAIN: move_gain <= wr_data;
        campose_pkg::REG_LIFT_GAIN: lift_gain <= wr_data;
        default: ;
      endcase
    end
  end

  // sequencer
  campose_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cmd_ch.valid),
    .cmd      (campose_pkg::cmd_t'(cmd_ch.cmd)),
    .out_free (out_free),
    .in_ready (in_ready),
    .ctl      (ctl)
  );

  assign cmd_ch.ready = in_ready;
  assign out_free     = !out_valid || pose_ch.ready;

  // multiplier operand select
  always_comb begin
    case (ctl.a_sel)
      campose_pkg::A_HD0: a_val = AW'(hd[0]);
      campose_pkg::A_HD1: a_val = AW'(hd[1]);
      campose_pkg::A_HD2: a_val = AW'(hd[2]);
      campose_pkg::A_UP0: a_val = AW'(up_x);
      campose_pkg::A_UP1: a_val = AW'(up_y);
      campose_pkg::A_UP2: a_val = AW'(up_z);
      campose_pkg::A_C0:  a_val = cc[0];
      campose_pkg::A_C1:  a_val = cc[1];
      campose_pkg::A_C2:  a_val = cc[2];
      campose_pkg::A_D:   a_val = dd;
      campose_pkg::A_T:   a_val = tt;
      default:            a_val = '0;
    endcase
  end

  // coefficient select
  always_comb begin
    case (ctl.b_sel)
      campose_pkg::B_UP0:  b_val = BW'(up_x);
      campose_pkg::B_UP1:  b_val = BW'(up_y);
      campose_pkg::B_UP2:  b_val = BW'(up_z);
      campose_pkg::B_MOVE: b_val = $signed(BW'(move_gain));
      campose_pkg::B_LIFT: b_val = $signed(BW'(lift_gain));
      campose_pkg::B_COS:  b_val = campose_pkg::ROT_COS;
      campose_pkg::B_SIN:  b_val = campose_pkg::ROT_SIN;
      campose_pkg::B_OMC:  b_val = campose_pkg::ROT_OMC;
      default:             b_val = '0;
    endcase
  end

  campose_mulsh #(
    .AW (AW)
  ) u_mulsh (
    .clk (clk),
    .op  (ctl.mul),
    .sh  (ctl.sh),
    .a   (a_val),
    .b   (b_val),
    .m   (m_val)
  );

  // current value of the destination
  always_comb begin
    case (ctl.dst)
      campose_pkg::D_POS0: dst_val = AW'(pos[0]);
      campose_pkg::D_POS1: dst_val = AW'(pos[1]);
      campose_pkg::D_POS2: dst_val = AW'(pos[2]);
      campose_pkg::D_HD0:  dst_val = AW'(hd[0]);
      campose_pkg::D_HD1:  dst_val = AW'(hd[1]);
      campose_pkg::D_HD2:  dst_val = AW'(hd[2]);
      campose_pkg::D_C0:   dst_val = cc[0];
      campose_pkg::D_C1:   dst_val = cc[1];
      campose_pkg::D_C2:   dst_val = cc[2];
      campose_pkg::D_D:    dst_val = dd;
      campose_pkg::D_T:    dst_val = tt;
      campose_pkg::D_R:    dst_val = rr;
      default:             dst_val = '0;
    endcase
  end

  // write-back adder
  always_comb begin
    case (ctl.base)
      campose_pkg::BASE_DST: base_val = dst_val;
      campose_pkg::BASE_R:   base_val = rr;
      default:               base_val = '0;
    endcase
    if (ctl.neg) begin
      res = SW'(base_val) - SW'(m_val);
    end else begin
      res = SW'(base_val) + SW'(m_val);
    end
  end

  // load pose operands
  assign ld_p[0] = SW'(cmd_ch.load_pos_x);
  assign ld_p[1] = SW'(cmd_ch.load_pos_y);
  assign ld_p[2] = SW'(cmd_ch.load_pos_z);
  assign ld_t[0] = SW'(cmd_ch.load_target_x);
  assign ld_t[1] = SW'(cmd_ch.load_target_y);
  assign ld_t[2] = SW'(cmd_ch.load_target_z);

  // pose state: load or saturating write-back
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        pos[i] <= '0;
        hd[i]  <= '0;
      end
    end else if (ctl.load) begin
      for (int i = 0; i < 3; i++) begin
        pos[i] <= sat_cw(ld_p[i]);
        hd[i]  <= sat_cw(ld_t[i] - ld_p[i]);
      end
    end else if (ctl.wr) begin
      case (ctl.dst)
        campose_pkg::D_POS0: pos[0] <= sat_cw(res);
        campose_pkg::D_POS1: pos[1] <= sat_cw(res);
        campose_pkg::D_POS2: pos[2] <= sat_cw(res);
        campose_pkg::D_HD0:  hd[0]  <= sat_cw(res);
        campose_pkg::D_HD1:  hd[1]  <= sat_cw(res);
        campose_pkg::D_HD2:  hd[2]  <= sat_cw(res);
        default: ;
      endcase
    end
  end

  // scratch registers for the rotation
  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      case (ctl.dst)
        campose_pkg::D_C0: cc[0] <= AW'(res);
        campose_pkg::D_C1: cc[1] <= AW'(res);
        campose_pkg::D_C2: cc[2] <= AW'(res);
        campose_pkg::D_D:  dd    <= AW'(res);
        campose_pkg::D_T:  tt    <= AW'(res);
        campose_pkg::D_R:  rr    <= AW'(res);
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (pose_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      for (int i = 0; i < 3; i++) begin
        out_cam[i]  <= campose_pkg::sat32(64'(pos[i]));
        out_look[i] <= campose_pkg::sat32(64'(pos[i]) + 64'(hd[i]));
      end
    end
  end

  assign pose_ch.valid  = out_valid;
  assign pose_ch.cam_x  = out_cam[0];
  assign pose_ch.cam_y  = out_cam[1];
  assign pose_ch.cam_z  = out_cam[2];
  assign pose_ch.look_x = out_look[0];
  assign pose_ch.look_y = out_look[1];
  assign pose_ch.look_z = out_look[2];

endmodule

`default_nettype wire

@@ hw/rtl/campose_mulsh.sv @@
// ----------------------------------------------------------------------------
// campose_mulsh: shared rounding multiplier
// Forms round(a * b / 2^s) exactly from two partial products: low half
// of a times b plus the rounding constant, then high half of a times b
// shifted in. The shifted result is read combinationally the cycle after.
// ----------------------------------------------------------------------------
`default_nettype none

module campose_mulsh #(
  parameter int AW = campose_pkg::COORD_BITS_DEFAULT + 8
) (
  input  logic                                  clk,
  input  campose_pkg::mul_op_t                  op,
  input  campose_pkg::shift_t                   sh,
  input  logic signed [AW-1:0]                  a,
  input  logic signed [campose_pkg::B_W-1:0]    b,
  output logic signed [AW-1:0]                  m
);

  localparam int LB = AW / 2;
  localparam int HW = LB + 1;
  localparam int PW = AW + campose_pkg::B_W;

  logic signed [HW-1:0]                    lo_op;
  logic signed [HW-1:0]                    hi_op;
  logic signed [HW-1:0]                    mul_a;
  logic signed [HW+campose_pkg::B_W-1:0]   prod;
  logic signed [PW-1:0]                    rnd;
  logic signed [PW-1:0]                    acc;
  logic signed [PW-1:0]                    acc_sh;

  // operand split: unsigned low half, signed high half
  assign lo_op = $signed({1'b0, a[LB-1:0]});
  assign hi_op = HW'($signed(a[AW-1:LB]));
  assign mul_a = (op == campose_pkg::MUL_HI) ? hi_op : lo_op;
  assign prod  = mul_a * b;

  // half-LSB rounding constant
  always_comb begin
    case (sh)
      campose_pkg::SH14: rnd = PW'(1) << 13;
      campose_pkg::SH16: rnd = PW'(1) << 15;
      campose_pkg::SH30: rnd = PW'(1) << 29;
      default:           rnd = '0;
    endcase
  end

  // accumulate the two partial products
  always_ff @(posedge clk) begin
    case (op)
      campose_pkg::MUL_LO: acc <= PW'(prod) + rnd;
      campose_pkg::MUL_HI: acc <= acc + (PW'(prod) <<< LB);
      default:             acc <= acc;
    endcase
  end

  // floor shift back to the destination scale
  always_comb begin
    case (sh)
      campose_pkg::SH14: acc_sh = acc >>> 14;
      campose_pkg::SH16: acc_sh = acc >>> 16;
      campose_pkg::SH30: acc_sh = acc >>> 30;
      default:           acc_sh = acc;
    endcase
  end

  assign m = acc_sh[AW-1:0];

endmodule

`default_nettype wire

@@ hw/rtl/campose_seq.sv @@
// ----------------------------------------------------------------------------
// campose_seq: command sequencer
// Walks the microcode program for the accepted command, each step through
// S_P0 (low product), S_P1 (high product) and S_P2 (write back), then hands
// the pose to the output register; load and none skip the program.
// ----------------------------------------------------------------------------
`default_nettype none

module campose_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  campose_pkg::cmd_t   cmd,
  input  logic                out_free,
  output logic                in_ready,
  output campose_pkg::ctl_t   ctl
);

  campose_pkg::seq_state_t             state, state_next;
  logic [campose_pkg::STEP_W-1:0]      step, step_next;
  campose_pkg::kind_t                  kind, kind_next;
  logic                                dir_neg, dir_neg_next;
  campose_pkg::uop_t                   uop;

  // state and program counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= campose_pkg::S_IDLE;
      step    <= '0;
      kind    <= campose_pkg::KIND_MOVE;
      dir_neg <= 1'b0;
    end else begin
      state   <= state_next;
      step    <= step_next;
      kind    <= kind_next;
      dir_neg <= dir_neg_next;
    end
  end

  // next state and control
  always_comb begin
    uop          = campose_pkg::uop_lookup(kind, step);
    state_next   = state;
    step_next    = step;
    kind_next    = kind;
    dir_neg_next = dir_neg;
    in_ready     = 1'b0;
    ctl.mul      = campose_pkg::MUL_HOLD;
    ctl.sh       = uop.sh;
    ctl.a_sel    = uop.a_sel;
    ctl.b_sel    = uop.b_sel;
    ctl.base     = uop.base;
    ctl.dst      = uop.dst;
    ctl.neg      = uop.neg ^ (uop.dirflip & dir_neg);
    ctl.wr       = 1'b0;
    ctl.load     = 1'b0;
    ctl.out_load = 1'b0;

    case (state)
      campose_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          step_next    = '0;
          dir_neg_next = (cmd inside {campose_pkg::CMD_BACK, campose_pkg::CMD_TURN_NEG,
                                      campose_pkg::CMD_DOWN});
          case (cmd)
            campose_pkg::CMD_FWD, campose_pkg::CMD_BACK: begin
              kind_next  = campose_pkg::KIND_MOVE;
              state_next = campose_pkg::S_P0;
            end
            campose_pkg::CMD_TURN_POS, campose_pkg::CMD_TURN_NEG: begin
              kind_next  = campose_pkg::KIND_TURN;
              state_next = campose_pkg::S_P0;
            end
            campose_pkg::CMD_DOWN, campose_pkg::CMD_UP: begin
              kind_next  = campose_pkg::KIND_LIFT;
              state_next = campose_pkg::S_P0;
            end
            campose_pkg::CMD_LOAD: begin
              ctl.load   = 1'b1;
              state_next = campose_pkg::S_OUT;
            end
            default: state_next = campose_pkg::S_OUT;
          endcase
        end
      end
      campose_pkg::S_P0: begin
        ctl.mul    = campose_pkg::MUL_LO;
        state_next = campose_pkg::S_P1;
      end
      campose_pkg::S_P1: begin
        ctl.mul    = campose_pkg::MUL_HI;
        state_next = campose_pkg::S_P2;
      end
      campose_pkg::S_P2: begin
        ctl.wr = 1'b1;
        if (uop.last) begin
          state_next = campose_pkg::S_OUT;
        end else begin
          step_next  = step + 1'b1;
          state_next = campose_pkg::S_P0;
        end
      end
      campose_pkg::S_OUT: begin
        if (out_free) begin
          ctl.out_load = 1'b1;
          state_next   = campose_pkg::S_IDLE;
        end
      end
      default: state_next = campose_pkg::S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/campose_checker.sv @@
// ----------------------------------------------------------------------------
// campose_checker: port-level checks for camera_pose_update
// Watches the command and pose channel handshakes; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module campose_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);

  // after reset the block is empty and takes commands
  a_reset_state: assert property (@(posedge clk)
    rst |=> (!out_valid && in_ready))
    else $error("block not idle after reset");

  // one command at a time: no new transfer right after one
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("command side ready right after a transfer");

  // a result never appears in the cycle after a command transfer
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !$rose(out_valid))
    else $error("result showed up too early");

  // a stalled result is not dropped
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("stalled result dropped");

endmodule

bind camera_pose_update campose_checker u_campose_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (cmd_ch.valid),
  .in_ready  (cmd_ch.ready),
  .out_valid (pose_ch.valid),
  .out_ready (pose_ch.ready)
);

`default_nettype wire
